[design/timestamp_to_calendar_fields_top_defines.svh]
// Assertion macros for the timestamp-to-calendar block.
// Used by the top level; relies on clk and arst_n being in scope.
`ifndef TIMESTAMP_TO_CALENDAR_FIELDS_TOP_DEFINES_SVH
`define TIMESTAMP_TO_CALENDAR_FIELDS_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TTC_ASSERT_SAME(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define TTC_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/ttc_pkg.sv]
// Shared types, constants and step functions for the timestamp-to-calendar block.
// No dependencies.
package ttc_pkg;

	localparam int unsigned FT_W       = 64;
	localparam int unsigned OUT_DATA_W = 56;

	localparam logic [63:0] UNITS_PER_MS   = 64'd10000;
	localparam logic [63:0] MAX_MS         = 64'h000346dc5d638865;
	localparam logic [63:0] FT_LIMIT       = (MAX_MS + 64'd1) * UNITS_PER_MS;
	localparam logic [63:0] UNITS_PER_DAY  = 64'd86400000 * UNITS_PER_MS;
	localparam logic [63:0] UNITS_PER_HOUR = 64'd3600000 * UNITS_PER_MS;
	localparam logic [63:0] UNITS_PER_MIN  = 64'd60000 * UNITS_PER_MS;
	localparam logic [63:0] UNITS_PER_SEC  = 64'd1000 * UNITS_PER_MS;

	localparam int unsigned DAY_BITS  = 24;
	localparam int unsigned HOUR_BITS = 5;
	localparam int unsigned MIN_BITS  = 6;
	localparam int unsigned SEC_BITS  = 6;
	localparam int unsigned MSEC_BITS = 10;
	localparam int unsigned HOUR_END  = DAY_BITS + HOUR_BITS;
	localparam int unsigned MIN_END   = HOUR_END + MIN_BITS;
	localparam int unsigned SEC_END   = MIN_END + SEC_BITS;
	localparam int unsigned SPLIT_STEPS = SEC_END + MSEC_BITS;

	localparam logic [23:0] DAYS_400Y = 24'd146097;
	localparam logic [23:0] NUM_100Y  = 24'd3652425;
	localparam logic [17:0] DAYS_100Y = 18'd36524;
	localparam logic [15:0] DAYS_4Y   = 16'd1461;
	localparam logic [17:0] NUM_1Y    = 18'd36525;
	localparam logic [10:0] DAYS_1Y   = 11'd365;
	localparam logic [14:0] BASE_YEAR = 15'd1601;

	localparam logic [8:0] START_NORM [13] = '{9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
		9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365};
	localparam logic [8:0] START_LEAP [13] = '{9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152,
		9'd182, 9'd213, 9'd244, 9'd274, 9'd305, 9'd335, 9'd366};

	typedef struct packed {
		logic [DAY_BITS-1:0]  days;
		logic [HOUR_BITS-1:0] hour;
		logic [MIN_BITS-1:0]  minute;
		logic [SEC_BITS-1:0]  second;
		logic [MSEC_BITS-1:0] msec;
	} clock_t;

	typedef struct packed {
		logic                   ok;
		logic [FT_W-1:0]        rem;
		logic [SPLIT_STEPS-1:0] quo;
		logic [2:0]             wmod;
	} split_t;

	typedef struct packed {
		logic       ok;
		clock_t     tod;
		logic [2:0] wmod;
	} tsplit_t;

	typedef struct packed {
		logic        ok;
		logic [14:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [2:0]  weekday;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
		logic [9:0]  millisecond;
	} cal_t;

	// Divisor for one restoring step of the mixed-radix split.
	function automatic logic [63:0] step_div(input int unsigned i);
		logic [63:0] d;
		if (i < DAY_BITS)
			d = UNITS_PER_DAY << (DAY_BITS - 1 - i);
		else if (i < HOUR_END)
			d = UNITS_PER_HOUR << (HOUR_END - 1 - i);
		else if (i < MIN_END)
			d = UNITS_PER_MIN << (MIN_END - 1 - i);
		else if (i < SEC_END)
			d = UNITS_PER_SEC << (SEC_END - 1 - i);
		else
			d = UNITS_PER_MS << (SPLIT_STEPS - 1 - i);
		return d;
	endfunction

	// (2w + b) mod 7, tracking the day count modulo 7 as its bits appear.
	function automatic logic [2:0] mod7_dbl(input logic [2:0] w, input logic b);
		logic [3:0] v;
		v = {w, b};
		return (v >= 4'd7) ? 3'(v - 4'd7) : v[2:0];
	endfunction

	function automatic split_t split_step(input split_t p, input int unsigned i);
		split_t      n;
		logic [63:0] d;
		logic        take;
		d    = step_div(i);
		take = (p.rem >= d);
		n    = p;
		if (take) begin
			n.rem = p.rem - d;
			n.quo[SPLIT_STEPS - 1 - i] = 1'b1;
		end
		if (i < DAY_BITS)
			n.wmod = mod7_dbl(p.wmod, take);
		return n;
	endfunction

	function automatic logic [8:0] month_start(input logic leap, input logic [3:0] m);
		return leap ? START_LEAP[m] : START_NORM[m];
	endfunction

endpackage

[design/ttc_split.sv]
// Pipelined mixed-radix long division of the 100 ns count into days and time of day.
// Depends on ttc_pkg.
module ttc_split import ttc_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_vld,
	input  logic [FT_W-1:0] file_time,
	output logic            out_vld,
	output tsplit_t         out_data
);

	split_t                 head;
	split_t                 nxt_s  [SPLIT_STEPS];
	split_t                 data_s [SPLIT_STEPS];
	logic [SPLIT_STEPS-1:0] vld_s;

	always_comb begin
		head.ok   = (file_time < FT_LIMIT);
		head.rem  = file_time;
		head.quo  = '0;
		head.wmod = '0;
	end

	// One quotient bit per stage.
	for (genvar i = 0; i < SPLIT_STEPS; i++) begin : g_step
		if (i == 0) begin : g_first
			assign nxt_s[i] = split_step(head, i);
		end else begin : g_rest
			assign nxt_s[i] = split_step(data_s[i-1], i);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s <= '0;
		else if (en)
			vld_s <= {vld_s[SPLIT_STEPS-2:0], in_vld};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < SPLIT_STEPS; i++)
				data_s[i] <= nxt_s[i];
		end
	end

	assign out_vld       = vld_s[SPLIT_STEPS-1];
	assign out_data.ok   = data_s[SPLIT_STEPS-1].ok;
	assign out_data.tod  = clock_t'(data_s[SPLIT_STEPS-1].quo);
	assign out_data.wmod = data_s[SPLIT_STEPS-1].wmod;

endmodule

[design/ttc_cal.sv]
// Pipelined day count to year, month, day and weekday; assembles the result.
// Depends on ttc_pkg.
module ttc_cal import ttc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    en,
	input  logic    in_vld,
	input  tsplit_t in_data,
	output logic    out_vld,
	output cal_t    out_data
);

	logic [7:0] vld_s;

	tsplit_t t_s1, t_s2, t_s3, t_s4, t_s5, t_s6, t_s7;
	logic [6:0]  a_s1, a_s2, a_s3, a_s4, a_s5, a_s6;
	logic [23:0] r_s1;
	logic [17:0] r_s2, r_s3;
	logic [23:0] n_s3;
	logic [1:0]  b_s4, b_s5, b_s6;
	logic [15:0] r_s4;
	logic [4:0]  c_s5, c_s6;
	logic [10:0] r_s5;
	logic [1:0]  e_s6;
	logic [8:0]  doy_s6, doy_s7;
	logic        leap_s6, leap_s7;
	logic [14:0] year_s7;
	logic [3:0]  m_s7;
	cal_t        out_s8;

	logic [23:0] r1, r2;
	logic [6:0]  a1, a2;
	logic [23:0] n3;
	logic [23:0] n4;
	logic [1:0]  b4;
	logic [17:0] r4;
	logic [15:0] r5;
	logic [4:0]  c5;
	logic [17:0] n6;
	logic [1:0]  e6;
	logic [10:0] doy6;
	logic [14:0] year7;
	logic [3:0]  m7;
	logic [8:0]  start8;
	cal_t        res8;

	// 400-year blocks, upper quotient bits.
	always_comb begin
		r1 = in_data.tod.days;
		a1 = '0;
		for (int k = 6; k >= 4; k--) begin
			if (r1 >= (DAYS_400Y << k)) begin
				r1 = r1 - (DAYS_400Y << k);
				a1[3'(k)] = 1'b1;
			end
		end
	end

	// 400-year blocks, lower quotient bits.
	always_comb begin
		r2 = r_s1;
		a2 = a_s1;
		for (int k = 3; k >= 0; k--) begin
			if (r2 >= (DAYS_400Y << k)) begin
				r2 = r2 - (DAYS_400Y << k);
				a2[3'(k)] = 1'b1;
			end
		end
	end

	assign n3 = {6'b0, r_s2} * 24'd100 + 24'd75;

	// Century within the 400-year block.
	always_comb begin
		n4 = n_s3;
		b4 = '0;
		for (int k = 1; k >= 0; k--) begin
			if (n4 >= (NUM_100Y << k)) begin
				n4 = n4 - (NUM_100Y << k);
				b4[1'(k)] = 1'b1;
			end
		end
		r4 = r_s3 - {16'b0, b4} * DAYS_100Y;
	end

	// 4-year blocks within the century.
	always_comb begin
		r5 = r_s4;
		c5 = '0;
		for (int k = 4; k >= 0; k--) begin
			if (r5 >= (DAYS_4Y << k)) begin
				r5 = r5 - (DAYS_4Y << k);
				c5[3'(k)] = 1'b1;
			end
		end
	end

	// Year within the 4-year block and day of year.
	always_comb begin
		n6 = {7'b0, r_s5} * 18'd100 + 18'd75;
		e6 = '0;
		for (int k = 1; k >= 0; k--) begin
			if (n6 >= (NUM_1Y << k)) begin
				n6 = n6 - (NUM_1Y << k);
				e6[1'(k)] = 1'b1;
			end
		end
		doy6 = r_s5 - {9'b0, e6} * DAYS_1Y;
	end

	// Year number and month search.
	always_comb begin
		year7 = {8'b0, a_s6} * 15'd400 + {13'b0, b_s6} * 15'd100 + {10'b0, c_s6} * 15'd4
			+ {13'b0, e_s6} + BASE_YEAR;
		m7 = '0;
		for (int j = 1; j < 12; j++) begin
			if (month_start(leap_s6, 4'(j)) <= doy_s6)
				m7 = 4'(j);
		end
	end

	// Day of month, weekday, and zero fill for out-of-range input.
	always_comb begin
		start8           = month_start(leap_s7, m_s7);
		res8.ok          = t_s7.ok;
		res8.year        = year_s7;
		res8.month       = m_s7 + 4'd1;
		res8.day         = 5'(doy_s7 - start8 + 9'd1);
		res8.weekday     = (t_s7.wmod == 3'd6) ? 3'd0 : t_s7.wmod + 3'd1;
		res8.hour        = t_s7.tod.hour;
		res8.minute      = t_s7.tod.minute;
		res8.second      = t_s7.tod.second;
		res8.millisecond = t_s7.tod.msec;
		if (!t_s7.ok)
			res8 = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s <= '0;
		else if (en)
			vld_s <= {vld_s[6:0], in_vld};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1 <= in_data;
			a_s1 <= a1;
			r_s1 <= r1;

			t_s2 <= t_s1;
			a_s2 <= a2;
			r_s2 <= r2[17:0];

			t_s3 <= t_s2;
			a_s3 <= a_s2;
			r_s3 <= r_s2;
			n_s3 <= n3;

			t_s4 <= t_s3;
			a_s4 <= a_s3;
			b_s4 <= b4;
			r_s4 <= r4[15:0];

			t_s5 <= t_s4;
			a_s5 <= a_s4;
			b_s5 <= b_s4;
			c_s5 <= c5;
			r_s5 <= r5[10:0];

			t_s6    <= t_s5;
			a_s6    <= a_s5;
			b_s6    <= b_s5;
			c_s6    <= c_s5;
			e_s6    <= e6;
			doy_s6  <= (doy6 > 11'd365) ? 9'd365 : doy6[8:0];
			leap_s6 <= (e6 == 2'd3) && ((c_s5 != 5'd24) || (b_s5 == 2'd3));

			t_s7    <= t_s6;
			year_s7 <= year7;
			m_s7    <= m7;
			doy_s7  <= doy_s6;
			leap_s7 <= leap_s6;

			out_s8 <= res8;
		end
	end

	assign out_vld  = vld_s[7];
	assign out_data = out_s8;

endmodule

[design/timestamp_to_calendar_fields_top.sv]
// Top level: 100 ns timestamp to Gregorian calendar fields, stream in and out.
// Depends on ttc_pkg, ttc_split, ttc_cal and timestamp_to_calendar_fields_top_defines.svh.
//
//  port group | dir | tdata                                  | tuser
//  -----------+-----+----------------------------------------+----------
//  s_axis     | in  | file_time[63:0]                        | -
//  m_axis     | out | year..millisecond, 54 bits + 2 pad     | valid_res
//
// One transfer in and one out per cycle, sustained unless a stall on m_axis fills the
// skid register. The pipeline has 51 long-division steps, one quotient bit each, then 8
// calendar stages, plus the output register. The 64-bit compare-subtract of one division
// step per stage sets the clock. Reset clears every valid bit; payload registers are not
// reset. A stall on m_axis fills a one-entry skid register; only then does s_axis_tready
// drop and the whole pipeline hold.
`include "timestamp_to_calendar_fields_top_defines.svh"

module timestamp_to_calendar_fields_top import ttc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [FT_W-1:0]       s_axis_tdata,  // [63:0] file_time
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// [14:0] year, [18:15] month, [23:19] day, [26:24] weekday, [31:27] hour,
	// [37:32] minute, [43:38] second, [53:44] millisecond, [55:54] zero
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	output logic                  m_axis_tuser   // [0] valid_res
);

	logic    en;
	logic    split_vld;
	tsplit_t split_data;
	logic    pipe_vld;
	cal_t    pipe_data;

	logic    out_vld_q;
	cal_t    out_q;
	logic    skid_vld_q;
	cal_t    skid_q;
	logic    out_free;
	logic    pipe_take;

	// Advance the pipeline whenever the skid slot is empty.
	assign en            = !skid_vld_q;
	assign s_axis_tready = en;

	ttc_split u_split (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_vld    (s_axis_tvalid),
		.file_time (s_axis_tdata),
		.out_vld   (split_vld),
		.out_data  (split_data)
	);

	ttc_cal u_cal (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (split_vld),
		.in_data  (split_data),
		.out_vld  (pipe_vld),
		.out_data (pipe_data)
	);

	// Output register is free when empty or its transfer completes this cycle.
	assign out_free  = !out_vld_q || m_axis_tready;
	assign pipe_take = pipe_vld && en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else begin
			if (out_free)
				out_vld_q <= skid_vld_q || pipe_take;
			if (skid_vld_q && out_free)
				skid_vld_q <= 1'b0;
			else if (pipe_take && !out_free)
				skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free)
			out_q <= skid_vld_q ? skid_q : pipe_data;
		// Park the finished result while the output register is stalled.
		if (!skid_vld_q && pipe_take && !out_free)
			skid_q <= pipe_data;
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tuser  = out_q.ok;
	assign m_axis_tdata  = {2'b00, out_q.millisecond, out_q.second, out_q.minute, out_q.hour,
		out_q.weekday, out_q.day, out_q.month, out_q.year};

	`TTC_ASSERT_SAME(a_skid_needs_out, skid_vld_q, out_vld_q, "skid full while output empty")
	`TTC_ASSERT_SAME(a_invalid_zero, out_vld_q && !out_q.ok, m_axis_tdata == '0, "fields not zero")
	`TTC_ASSERT_SAME(a_field_range, out_vld_q && out_q.ok, out_q.month >= 4'd1 && out_q.month <= 4'd12 && out_q.hour <= 5'd23, "field out of range")
	`TTC_ASSERT_NEXT(a_stall_parks, out_vld_q && !m_axis_tready && pipe_vld && !skid_vld_q, skid_vld_q, "result not parked")

endmodule

[test/tb_timestamp_to_calendar_fields_top.sv]
// Testbench for timestamp_to_calendar_fields_top: drives 100 ns timestamps on the input
// stream and checks every calendar transfer against an in-bench date predictor.
// Depends on ttc_pkg and the RTL of the block.

module tb_timestamp_to_calendar_fields_top import ttc_pkg::*;;

	localparam int unsigned LATENCY = 64;
	localparam int unsigned RANDOM_ITEMS = 1500;

	typedef struct packed {
		logic        ok;
		logic [14:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [2:0]  weekday;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
		logic [9:0]  msec;
	} date_fields_t;

	// Work out the calendar fields of one timestamp.
	function automatic date_fields_t calendar_of(input logic [63:0] ft);
		date_fields_t r;
		longint unsigned ms, days, msd, d, q400, q100, q4, yrs, doy, secs, mins, y1;
		int unsigned m;
		logic leap;
		int unsigned starts [13];
		r = '0;
		ms = ft / 64'd10000;
		if (ms > 64'h000346dc5d638865)
			return r;
		days = ms / 64'd86400000;
		msd = ms - days * 64'd86400000;
		r.weekday = 3'((days + 1) % 7);
		d = days;
		q400 = d / 146097;
		d -= q400 * 146097;
		q100 = (d * 100 + 75) / 3652425;
		d -= q100 * 36524;
		q4 = d / 1461;
		d -= q4 * 1461;
		yrs = q400 * 400 + q100 * 100 + q4 * 4 + (d * 100 + 75) / 36525;
		doy = days - (yrs * 365 + yrs / 4 - yrs / 100 + yrs / 400);
		if (doy > 365)
			doy = 365;
		y1 = yrs + 1;
		leap = (y1 % 4 == 0) && ((y1 % 100 != 0) || (y1 % 400 == 0));
		if (leap)
			starts = '{0, 31, 60, 91, 121, 152, 182, 213, 244, 274, 305, 335, 366};
		else
			starts = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334, 365};
		m = 0;
		while (m < 11 && starts[m + 1] <= doy)
			m++;
		secs = msd / 1000;
		mins = secs / 60;
		r.ok = 1'b1;
		r.year = 15'(yrs + 1601);
		r.month = 4'(m + 1);
		r.day = 5'(doy - starts[m] + 1);
		r.hour = 5'(mins / 60);
		r.minute = 6'(mins % 60);
		r.second = 6'(secs % 60);
		r.msec = 10'(msd % 1000);
		return r;
	endfunction

	class calendar_scoreboard;
		date_fields_t pending [$];
		int errors;
		int checked;

		function void note_timestamp(input logic [63:0] ft);
			pending.push_back(calendar_of(ft));
		endfunction

		function void report(input string field, input int unsigned want, input int unsigned got);
			errors++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
		endfunction

		function void check_result(input logic [OUT_DATA_W-1:0] data, input logic flag);
			date_fields_t want, got;
			got = {flag, data[14:0], data[18:15], data[23:19], data[26:24], data[31:27],
				data[37:32], data[43:38], data[53:44]};
			checked++;
			if (pending.size() == 0) begin
				errors++;
				$display("%0t: unexpected result %h", $time, got);
				return;
			end
			want = pending.pop_front();
			if (got.ok !== want.ok) report("valid_res", want.ok, got.ok);
			if (got.year !== want.year) report("year", want.year, got.year);
			if (got.month !== want.month) report("month", want.month, got.month);
			if (got.day !== want.day) report("day", want.day, got.day);
			if (got.weekday !== want.weekday) report("weekday", want.weekday, got.weekday);
			if (got.hour !== want.hour) report("hour", want.hour, got.hour);
			if (got.minute !== want.minute) report("minute", want.minute, got.minute);
			if (got.second !== want.second) report("second", want.second, got.second);
			if (got.msec !== want.msec) report("millisecond", want.msec, got.msec);
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [FT_W-1:0]       s_axis_tdata;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  m_axis_tuser;

	calendar_scoreboard sb;
	int  sent;
	int  hold_off;     // cycles left in the long receiver stall
	bit  long_hold_done;

	timestamp_to_calendar_fields_top DUT (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Days from 1601-01-01 to the first of January of 1601 + y.
	function automatic longint unsigned calendar_days(input longint unsigned y);
		return y * 365 + y / 4 - y / 100 + y / 400;
	endfunction

	// Pick a random timestamp: mostly valid dates, some around the limit, some noise.
	function automatic logic [63:0] random_timestamp();
		logic [63:0] v;
		case ($urandom_range(9))
			0: v = {$urandom, $urandom};
			1: v = FT_LIMIT - 64'd20000 + 64'($urandom_range(40000));
			2: v = 64'($urandom_range(1000000)) * UNITS_PER_DAY + 64'($urandom);
			// near a year boundary: around Dec 31 / Jan 1 of a random year
			3: v = 64'(calendar_days($urandom_range(29226))) * UNITS_PER_DAY
				- 64'd1000 + 64'($urandom_range(2000)) * UNITS_PER_HOUR / 64'd100;
			default: v = ({$urandom, $urandom} % FT_LIMIT);
		endcase
		return v;
	endfunction

	// Offer one timestamp and hold it until the block takes it.
	task automatic send_timestamp(input logic [63:0] ft);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= ft;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		sb.note_timestamp(ft);
		sent++;
	endtask

	task automatic idle_gap(input int unsigned n);
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= {$urandom, $urandom};
		repeat (n) @(posedge clk);
	endtask

	// Receiver: stall on its own pattern; once, hold off long enough to fill the block.
	initial begin
		int unsigned phase;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			phase = $urandom_range(15);
			if (hold_off > 0) begin
				hold_off--;
				m_axis_tready <= 1'b0;
			end else if (sent > 300 && !long_hold_done) begin
				long_hold_done = 1;
				hold_off = 200;
				m_axis_tready <= 1'b0;
			end else if (sent > 900 && sent < 1100) begin
				m_axis_tready <= 1'b1;  // stretch with no stalls
			end else begin
				m_axis_tready <= (phase > 4);
			end
		end
	end

	// Check every output transfer.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata, m_axis_tuser);
	end

	initial begin
		#20000000;
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		logic [63:0] directed [$];
		int unsigned burst, wait_cycles;
		sb = new();
		sent = 0;
		hold_off = 0;
		long_hold_done = 0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Epoch, sub-millisecond truncation, leap days, century rules, limit and beyond.
		directed = '{64'd0, 64'd9999, 64'd10000, UNITS_PER_DAY - 64'd1, UNITS_PER_DAY,
			64'(calendar_days(3) + 59) * UNITS_PER_DAY,              // 1604-02-29
			64'(calendar_days(3) + 365) * UNITS_PER_DAY,             // 1604-12-31
			64'(calendar_days(399) + 365) * UNITS_PER_DAY,           // 2000-12-31
			64'(calendar_days(299) + 59) * UNITS_PER_DAY,            // 1900-03-01
			64'(calendar_days(399)) * UNITS_PER_DAY - 64'd1,         // 1999-12-31 end
			64'(calendar_days(400)) * UNITS_PER_DAY,                 // 2001-01-01
			FT_LIMIT - 64'd1, FT_LIMIT, FT_LIMIT - 64'd10000,
			64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
			64'h5555_5555_5555_5555, 64'h2AAA_AAAA_AAAA_AAAA,
			64'h0155_5555_5555_5555, 64'h00AA_AAAA_AAAA_AAAA};
		foreach (directed[i])
			send_timestamp(directed[i]);

		while (sent < directed.size() + RANDOM_ITEMS) begin
			burst = $urandom_range(1, 40);
			repeat (burst)
				send_timestamp(random_timestamp());
			wait_cycles = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
			if (wait_cycles > 0)
				idle_gap(wait_cycles);
		end
		s_axis_tvalid <= 1'b0;

		while (sb.pending.size() > 0)
			@(posedge clk);
		repeat (LATENCY) @(posedge clk);

		$display("Covered %0d timestamps: epoch, leap and century days, the valid limit, "
			, sent);
		$display("overflow values and random dates under bursty input and output stalls.");
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
